[hw/rtl/hbd_pkg.sv]
// ----------------------------------------------------------------------------
// hbd_pkg: shared definitions for the halfband decimator
// Widths, codes, sequencer states and the arithmetic helpers of the datapath.
// ----------------------------------------------------------------------------
package hbd_pkg;

	// default largest group count (filter of 4G+3 taps)
	localparam int MAX_GROUPS_DEF = 15;

	// fixed field widths
	localparam int DW  = 32;  // sample, coefficient and result width
	localparam int GW  = 4;   // tap_groups width
	localparam int CIW = 5;   // coef_index width
	// tap step counter, runs 0..2G+2 with G at most 15
	localparam int JW  = 6;
	// age of a sample inside a step, at most 4G+2 with G at most 15
	localparam int AGW = 7;
	// reset value of tap_groups
	localparam logic [GW-1:0] TAP_GROUPS_RST = 4'd15;

	// operation codes of an input word
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_COEF   = 1'b1;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_RUN   = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	// upper half of the signed 64-bit product, i.e. floor(x*c / 2^32)
	function automatic logic [DW-1:0] mul_high(input logic signed [DW-1:0] x,
		input logic signed [DW-1:0] c);
		logic signed [2*DW-1:0] p;
		p = x * c;
		return p[2*DW-1:DW];
	endfunction

	// centre tap of 0.5 before the final doubling: arithmetic shift by two
	function automatic logic [DW-1:0] quarter(input logic signed [DW-1:0] x);
		logic signed [DW-1:0] r;
		r = x >>> 2;
		return r;
	endfunction

endpackage

[hw/rtl/halfband_decimator_q31.sv]
// ----------------------------------------------------------------------------
// halfband_decimator_q31: Q1.31 halfband FIR decimator by two
// Samples go into a circular delay-line memory; every other sample starts a
// multiply-accumulate pass over the even taps and the fixed centre tap.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake              payload
//  in       input      in_valid / in_ready    operation, sample, coef_index, coef_value
//  out      output     out_valid / out_ready  filtered
//  cfg      input      cfg_valid / cfg_ready  cfg_data (tap_groups)
//
// A coefficient word or a sample that gives no output is taken in the idle state.
// A sample that gives an output holds the input through reads of the delay-line
// and coefficient memories (one read port each) for the even taps, via the one
// shared multiplier, and the centre tap, then pipeline drain and output load.
// After reset the delay line reads as zero through a fill count and the
// coefficients through per-entry valid bits; there is no clearing pass.
// A result left waiting in the output register stalls the next output and the input.
// ----------------------------------------------------------------------------
module halfband_decimator_q31 #(
	parameter int MAX_GROUPS = hbd_pkg::MAX_GROUPS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input words
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          operation,
	input  logic signed [hbd_pkg::DW-1:0] sample,
	input  logic [hbd_pkg::CIW-1:0]       coef_index,
	input  logic signed [hbd_pkg::DW-1:0] coef_value,
	// output words
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [hbd_pkg::DW-1:0] filtered,
	// configuration
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [hbd_pkg::GW-1:0]        cfg_data
);

	localparam int DL_DEPTH = 4 * MAX_GROUPS + 3;
	localparam int CS_DEPTH = 2 * MAX_GROUPS + 2;
	// only the first 32 coefficients are reachable by coef_index
	localparam int CM    = (CS_DEPTH < 32) ? CS_DEPTH : 32;
	localparam int AW    = $clog2(DL_DEPTH);
	localparam int DLM   = 2 ** AW;
	localparam int CAW   = $clog2(CM);
	localparam int CNTW  = $clog2(DL_DEPTH + 1);

	// storage
	logic [hbd_pkg::DW-1:0] dl_mem   [DLM];
	logic [hbd_pkg::DW-1:0] coef_mem [CM];

	// control state
	hbd_pkg::state_t        state_q;
	logic                   phase_q;
	logic [AW-1:0]          wp_q;
	logic [CNTW-1:0]        fill_q;
	logic [CM-1:0]          coef_vld_q;
	logic [hbd_pkg::GW-1:0] tap_groups_q;
	logic [hbd_pkg::GW-1:0] g_q;
	logic [hbd_pkg::JW-1:0] j_q;
	logic                   out_valid_q;

	// pipeline
	logic                   v_s1, ctr_s1, last_s1, dl_ok_s1, coef_ok_s1;
	logic [hbd_pkg::DW-1:0] dl_rd_s1, coef_rd_s1;
	logic                   v_s2, last_s2;
	logic [hbd_pkg::DW-1:0] term_s2;
	logic [hbd_pkg::DW-1:0] acc_q;
	logic [hbd_pkg::DW-1:0] filtered_q;

	// combinational
	logic                   in_acc, out_acc, out_load, start, issue, is_ctr;
	logic [hbd_pkg::GW-1:0] g_eff;
	logic [hbd_pkg::JW-1:0] j_last;
	logic [hbd_pkg::AGW-1:0] age;
	logic [AW-1:0]          dl_addr;
	logic [CAW-1:0]         coef_addr;
	logic [AW-1:0]          wp_next;
	logic                   coef_wr;
	logic [hbd_pkg::DW-1:0] x_s1, c_s1;

	assign in_ready  = (state_q == hbd_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign filtered  = filtered_q;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid_q && out_ready;
	assign start   = in_acc && (operation == hbd_pkg::OP_SAMPLE) && !phase_q;
	assign issue   = (state_q == hbd_pkg::ST_RUN);
	assign wp_next = wp_q + AW'(1);
	assign coef_wr = in_acc && (operation == hbd_pkg::OP_COEF)
		&& (int'(coef_index) < CM);

	// finished sum moves to the output register once that is free
	assign out_load = (state_q == hbd_pkg::ST_DONE) && (!out_valid_q || out_ready);

	// group count clipped to the largest supported one
	assign g_eff = (int'(tap_groups_q) > MAX_GROUPS) ? hbd_pkg::GW'(MAX_GROUPS)
		: tap_groups_q;

	// step addressing: steps 0..2G+1 are even taps, step 2G+2 the centre tap
	assign j_last    = hbd_pkg::JW'({g_q, 1'b0}) + hbd_pkg::JW'(2);
	assign is_ctr    = (j_q == j_last);
	assign age       = is_ctr
		? hbd_pkg::AGW'({g_q, 1'b0}) + hbd_pkg::AGW'(1)
		: hbd_pkg::AGW'({g_q, 2'b00}) + hbd_pkg::AGW'(2)
			- hbd_pkg::AGW'({j_q, 1'b0});
	assign dl_addr   = wp_q - AW'(age);
	assign coef_addr = CAW'(j_q);

	// sequencer and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= hbd_pkg::ST_IDLE;
			phase_q      <= 1'b0;
			wp_q         <= '0;
			fill_q       <= '0;
			coef_vld_q   <= '0;
			tap_groups_q <= hbd_pkg::TAP_GROUPS_RST;
			out_valid_q  <= 1'b0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				tap_groups_q <= cfg_data;
			end
			if (coef_wr) begin
				coef_vld_q[CAW'(coef_index)] <= 1'b1;
			end
			if (in_acc && (operation == hbd_pkg::OP_SAMPLE)) begin
				wp_q    <= wp_next;
				phase_q <= !phase_q;
				if (int'(fill_q) < DL_DEPTH) begin
					fill_q <= fill_q + CNTW'(1);
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_acc) begin
				out_valid_q <= 1'b0;
			end
			v_s1 <= issue;
			v_s2 <= v_s1;
			unique case (state_q)
				hbd_pkg::ST_IDLE: begin
					if (start) begin
						state_q <= hbd_pkg::ST_RUN;
					end
				end
				hbd_pkg::ST_RUN: begin
					if (is_ctr) begin
						state_q <= hbd_pkg::ST_DRAIN;
					end
				end
				hbd_pkg::ST_DRAIN: begin
					if (v_s2 && last_s2) begin
						state_q <= hbd_pkg::ST_DONE;
					end
				end
				hbd_pkg::ST_DONE: begin
					if (out_load) begin
						state_q <= hbd_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= hbd_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// step counter and captured group count
	always_ff @(posedge clk) begin
		if (start) begin
			g_q <= g_eff;
			j_q <= '0;
		end else if (issue) begin
			j_q <= j_q + hbd_pkg::JW'(1);
		end
	end

	// delay-line memory: write newest sample, registered read
	always_ff @(posedge clk) begin
		if (in_acc && (operation == hbd_pkg::OP_SAMPLE)) begin
			dl_mem[wp_next] <= sample;
		end
		dl_rd_s1 <= dl_mem[dl_addr];
	end

	// coefficient memory: write one tap, registered read
	always_ff @(posedge clk) begin
		if (coef_wr) begin
			coef_mem[CAW'(coef_index)] <= coef_value;
		end
		coef_rd_s1 <= coef_mem[coef_addr];
	end

	// stage 1 side information: never-written entries read as zero
	always_ff @(posedge clk) begin
		ctr_s1     <= is_ctr;
		last_s1    <= is_ctr;
		dl_ok_s1   <= (CNTW'(age) < fill_q);
		coef_ok_s1 <= coef_vld_q[coef_addr];
	end

	assign x_s1 = dl_ok_s1 ? dl_rd_s1 : '0;
	assign c_s1 = coef_ok_s1 ? coef_rd_s1 : '0;

	// stage 2: one product, or the centre tap term
	always_ff @(posedge clk) begin
		term_s2 <= ctr_s1 ? hbd_pkg::quarter(x_s1) : hbd_pkg::mul_high(x_s1, c_s1);
		last_s2 <= last_s1;
	end

	// accumulator, wraps at 32 bits
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + term_s2;
		end
	end

	// output register, final doubling drops the top bit
	always_ff @(posedge clk) begin
		if (out_load) begin
			filtered_q <= {acc_q[hbd_pkg::DW-2:0], 1'b0};
		end
	end

endmodule

[test/halfband_decimator_q31_tb.sv]
// ----------------------------------------------------------------------------
// halfband_decimator_q31_tb: self-checking bench for the halfband decimator
// Sample and coefficient words go in with random idling on both channels.
// A bit-exact filter model predicts each decimated output word, and every
// output word is compared against the oldest prediction. A directed table
// comes first, then random phases over several tap-group settings.
// ----------------------------------------------------------------------------
module halfband_decimator_q31_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DW  = hbd_pkg::DW;
	localparam int CIW = hbd_pkg::CIW;
	localparam int GW  = hbd_pkg::GW;
	localparam logic OP_SAMPLE = hbd_pkg::OP_SAMPLE;
	localparam logic OP_COEF   = hbd_pkg::OP_COEF;
	localparam logic [GW-1:0] TAP_GROUPS_RST = hbd_pkg::TAP_GROUPS_RST;

	localparam int MAX_G       = hbd_pkg::MAX_GROUPS_DEF;
	localparam int HIST_DEPTH  = 4 * MAX_G + 3;
	localparam int COEF_DEPTH  = 2 * MAX_G + 2;
	// longest output computation plus margin for the datapath to go quiet
	localparam int SETTLE      = 2 * MAX_G + 7 + 32;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int PHASES      = 8;
	localparam int PHASE_WORDS = 180;

	typedef enum logic {ROW_WORD, ROW_GROUPS} row_kind_t;

	typedef struct packed {
		row_kind_t      kind;
		logic           op;
		logic [DW-1:0]  smp;
		logic [CIW-1:0] idx;
		logic [DW-1:0]  val;        // coefficient, or tap_groups on a ROW_GROUPS row
		logic           known;
		logic [DW-1:0]  known_out;
	} dir_row_t;

	logic           clk;
	logic           arst_n;
	logic           in_valid;
	logic           in_ready;
	logic           operation;
	logic [DW-1:0]  sample;
	logic [CIW-1:0] coef_index;
	logic [DW-1:0]  coef_value;
	logic           out_valid;
	logic           out_ready;
	logic [DW-1:0]  filtered;
	logic           cfg_valid;
	logic           cfg_ready;
	logic [GW-1:0]  cfg_data;

	// filter model state
	logic [DW-1:0]  hist [HIST_DEPTH];
	logic [DW-1:0]  coefs [COEF_DEPTH];
	logic           skip_next;
	logic [GW-1:0]  groups;

	logic [DW-1:0]  pending_out [$];
	int             mismatches = 0;
	int             cycles = 0;
	logic           calm = 1'b0;

	halfband_decimator_q31 #(.MAX_GROUPS(MAX_G)) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.operation  (operation),
		.sample     (sample),
		.coef_index (coef_index),
		.coef_value (coef_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.filtered   (filtered),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("halfband_decimator_q31: mismatch");
			$finish;
		end
	end

	// filter model: takes one input word, gives at most one output word
	task automatic filter_word(input logic op, input logic [DW-1:0] smp,
		input logic [CIW-1:0] idx, input logic [DW-1:0] val,
		output logic produced, output logic [DW-1:0] y);
		int g;
		int j;
		int k;
		logic [DW-1:0] acc;
		logic [DW-1:0] tap;
		logic [DW-1:0] ctr;
		logic signed [2*DW-1:0] xw;
		logic signed [2*DW-1:0] cw;
		logic signed [2*DW-1:0] p;
		produced = 1'b0;
		y = '0;
		if (op == OP_COEF) begin
			// indexes beyond the store are dropped
			if (int'(idx) < COEF_DEPTH)
				coefs[idx] = val;
		end else begin
			for (k = HIST_DEPTH - 1; k > 0; k--)
				hist[k] = hist[k - 1];
			hist[0] = smp;
			if (skip_next) begin
				skip_next = 1'b0;
			end else begin
				skip_next = 1'b1;
				g = (int'(groups) > MAX_G) ? MAX_G : int'(groups);
				acc = '0;
				// even taps: coefficient j meets the sample of age 4G+2-2j
				for (j = 0; j < 2 * g + 2; j++) begin
					tap = hist[4 * g + 2 - 2 * j];
					xw = {{DW{tap[DW-1]}}, tap};
					cw = {{DW{coefs[j][DW-1]}}, coefs[j]};
					p = xw * cw;
					acc = acc + p[2*DW-1:DW];
				end
				// centre tap of one half, then the final doubling
				ctr = hist[2 * g + 1];
				acc = acc + {{2{ctr[DW-1]}}, ctr[DW-1:2]};
				y = acc << 1;
				produced = 1'b1;
			end
		end
	endtask

	// random q1.31 value, now and then an extreme or a small one
	function automatic logic [DW-1:0] pick_q31();
		case ($urandom_range(0, 9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'($urandom_range(0, 63)) - 32'd32;
			default: return $urandom();
		endcase
	endfunction

	// one input word: present it, wait for the handshake, then idle
	task automatic send_word(input logic op, input logic [DW-1:0] smp,
		input logic [CIW-1:0] idx, input logic [DW-1:0] val,
		input logic known, input logic [DW-1:0] known_out);
		int gap;
		logic produced;
		logic [DW-1:0] y;
		operation <= op;
		sample <= smp;
		coef_index <= idx;
		coef_value <= val;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_ready !== 1'b1);
		filter_word(op, smp, idx, val, produced, y);
		if (produced)
			pending_out.push_back(known ? known_out : y);
		gap = calm ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// hold the input until every predicted word is out, then let it settle
	task automatic drain_outputs();
		in_valid <= 1'b0;
		while (pending_out.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// tap_groups write, only ever with the block idle
	task automatic set_groups(input logic [GW-1:0] g);
		drain_outputs();
		cfg_data <= g;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		groups = g;
	endtask

	// output side: random stall per word, then check against the oldest prediction
	initial begin : sink
		int stall;
		logic [DW-1:0] want;
		forever begin
			stall = calm ? 0 : $urandom_range(0, 9);
			out_ready <= (stall == 0);
			if (stall > 0) begin
				repeat (stall) @(posedge clk);
				out_ready <= 1'b1;
			end
			do @(posedge clk); while (out_valid !== 1'b1);
			if (pending_out.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("filtered: no word expected, got %h", filtered);
			end else begin
				want = pending_out.pop_front();
				if (filtered !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("filtered: expected %h, got %h", want, filtered);
				end
			end
		end
	end

	// stimulus
	initial begin : stimulus
		dir_row_t dir_tab [$];
		int ph;
		int n;
		int j;
		logic [GW-1:0] g;
		logic op;

		arst_n <= 1'b0;
		in_valid <= 1'b0;
		operation <= OP_SAMPLE;
		sample <= '0;
		coef_index <= '0;
		coef_value <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;

		foreach (hist[k])
			hist[k] = '0;
		foreach (coefs[k])
			coefs[k] = '0;
		skip_next = 1'b0;
		groups = TAP_GROUPS_RST;

		// directed words; 15 tap groups from reset first
		// first sample after reset: all coefficients zero, centre sample zero
		dir_tab.push_back('{ROW_WORD, OP_SAMPLE, 32'h7FFF_FFFF, 5'd0, 32'd0, 1'b1, 32'd0});
		dir_tab.push_back('{ROW_WORD, OP_SAMPLE, 32'h8000_0000, 5'd31, 32'd0, 1'b0, 32'd0});
		dir_tab.push_back('{ROW_WORD, OP_COEF, 32'd0, 5'd0, 32'h7FFF_FFFF, 1'b0, 32'd0});
		dir_tab.push_back('{ROW_WORD, OP_COEF, 32'd0, 5'd31, 32'h8000_0000, 1'b0, 32'd0});
		dir_tab.push_back('{ROW_WORD, OP_COEF, 32'hFFFF_FFFF, 5'd16, 32'd1, 1'b0, 32'd0});
		dir_tab.push_back('{ROW_WORD, OP_SAMPLE, 32'd0, 5'd0, 32'd0, 1'b0, 32'd0});
		dir_tab.push_back('{ROW_WORD, OP_SAMPLE, 32'hFFFF_FFFF, 5'd31, 32'hFFFF_FFFF,
			1'b0, 32'd0});
		dir_tab.push_back('{ROW_WORD, OP_SAMPLE, 32'h5555_5555, 5'd10, 32'h5555_5555,
			1'b0, 32'd0});
		dir_tab.push_back('{ROW_WORD, OP_SAMPLE, 32'hAAAA_AAAA, 5'd21, 32'hAAAA_AAAA,
			1'b0, 32'd0});
		// shortest filter over the samples already held
		dir_tab.push_back('{ROW_GROUPS, OP_SAMPLE, 32'd0, 5'd0, 32'd0, 1'b0, 32'd0});
		dir_tab.push_back('{ROW_WORD, OP_COEF, 32'd0, 5'd0, 32'h8000_0000, 1'b0, 32'd0});
		dir_tab.push_back('{ROW_WORD, OP_COEF, 32'd0, 5'd1, 32'h8000_0000, 1'b0, 32'd0});
		dir_tab.push_back('{ROW_WORD, OP_SAMPLE, 32'h8000_0000, 5'd0, 32'd0, 1'b0, 32'd0});
		dir_tab.push_back('{ROW_WORD, OP_SAMPLE, 32'h8000_0000, 5'd0, 32'd0, 1'b0, 32'd0});
		// most negative everywhere: the sums wrap and the doubling drops the top bit
		dir_tab.push_back('{ROW_WORD, OP_SAMPLE, 32'h8000_0000, 5'd0, 32'd0,
			1'b1, 32'hC000_0000});
		dir_tab.push_back('{ROW_WORD, OP_SAMPLE, 32'h7FFF_FFFF, 5'd0, 32'd0, 1'b0, 32'd0});
		dir_tab.push_back('{ROW_WORD, OP_SAMPLE, 32'h7FFF_FFFF, 5'd0, 32'd0, 1'b0, 32'd0});
		dir_tab.push_back('{ROW_WORD, OP_COEF, 32'd0, 5'd1, 32'h7FFF_FFFF, 1'b0, 32'd0});
		dir_tab.push_back('{ROW_WORD, OP_SAMPLE, 32'h7FFF_FFFF, 5'd0, 32'd0, 1'b0, 32'd0});
		dir_tab.push_back('{ROW_WORD, OP_SAMPLE, 32'h7FFF_FFFF, 5'd0, 32'd0, 1'b0, 32'd0});

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[r]) begin
			if (dir_tab[r].kind == ROW_GROUPS)
				set_groups(dir_tab[r].val[GW-1:0]);
			else
				send_word(dir_tab[r].op, dir_tab[r].smp, dir_tab[r].idx, dir_tab[r].val,
					dir_tab[r].known, dir_tab[r].known_out);
		end

		// random phases, each with its own tap_groups and a fresh coefficient set
		for (ph = 0; ph < PHASES; ph++) begin
			case (ph) inside
				0, 7: g = 4'd0;
				1, 5: g = 4'd15;
				3: g = 4'd1;
				default: g = 4'($urandom_range(2, 14));
			endcase
			set_groups(g);
			for (j = 0; j < 2 * int'(g) + 2; j++)
				send_word(OP_COEF, pick_q31(), 5'(j), pick_q31(), 1'b0, '0);
			for (n = 0; n < PHASE_WORDS; n++) begin
				if (n % 64 == 0)
					calm = ($urandom_range(0, 3) == 0);
				// hold the input back until the output side has caught up
				if ((ph == 2 && n == PHASE_WORDS / 2) || $urandom_range(0, 199) == 0)
					drain_outputs();
				op = ($urandom_range(0, 7) == 0) ? OP_COEF : OP_SAMPLE;
				send_word(op, pick_q31(), 5'($urandom_range(0, 31)), pick_q31(), 1'b0, '0);
			end
		end

		drain_outputs();
		if (mismatches == 0 && pending_out.size() == 0)
			$display("halfband_decimator_q31: match");
		else
			$display("halfband_decimator_q31: mismatch");
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/hbd_pkg.sv
hw/rtl/halfband_decimator_q31.sv
test/halfband_decimator_q31_tb.sv
